@@ sv/structural_hash_table_core_assert.svh @@
// Assertion macros for the structural hash table core
`ifndef STRUCTURAL_HASH_TABLE_CORE_ASSERT_SVH
`define STRUCTURAL_HASH_TABLE_CORE_ASSERT_SVH
`define SHT_ASSERT_IMP(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("implication failed");
`define SHT_ASSERT_NXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("next-cycle check failed");
`endif

@@ sv/sht_pkg.sv @@
// Shared types and constants for the structural hash table
package sht_pkg;
  localparam int TABLE_DEPTH_DEF = 4096;
  localparam int NODE_ID_BITS_DEF = 16;
  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_ABSENT = 2'd3;
  localparam logic [12:0] SIZE_RESET = 13'd4093;
  localparam logic [0:0] REG_TABLE_SIZE = 1'b0;
  localparam logic [0:0] REG_REF_CHECK = 1'b1;
  typedef enum logic [1:0] {FE_IDLE, FE_MOD, FE_PUSH} fe_state_t;
  typedef enum logic [3:0] {
    BE_IDLE, BE_RD, BE_WAIT, BE_CHK, BE_REPL_RD, BE_REPL_WAIT, BE_REPL_CHK,
    BE_REH_MOD, BE_REH_PROBE_RD, BE_REH_PROBE_WAIT, BE_REH_PROBE_CHK, BE_DONE
  } be_state_t;
endpackage

@@ sv/structural_hash_table_core.sv @@
// The front end takes a new transfer only when idle, after it has queued the last one;
// the back end takes one item at a time.
// A delete also moves each following cluster entry, rehashing and re-probing it.
// The 28-step remainder by the table size runs as shift and subtract.
// Reset: synchronous, active low; zero count, size 4093, then a pass over every slot
// clears the valid store before the back end starts.
module structural_hash_table_core #(
  parameter int TABLE_DEPTH = sht_pkg::TABLE_DEPTH_DEF,
  parameter int NODE_ID_BITS = sht_pkg::NODE_ID_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [0:0]              cfg_index,
  input  logic [12:0]             cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_operation,
  input  logic                    in_is_exor,
  input  logic [NODE_ID_BITS-1:0] in_fanin0_id,
  input  logic [NODE_ID_BITS-1:0] in_fanin1_id,
  input  logic                    in_fanin0_inverted,
  input  logic                    in_fanin1_inverted,
  input  logic                    in_fanin0_referenced,
  input  logic                    in_fanin1_referenced,
  input  logic [NODE_ID_BITS-1:0] in_entry_node_id,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              out_status,
  output logic [NODE_ID_BITS-1:0] out_found_node_id
);
  localparam int IDX_BITS = $clog2(TABLE_DEPTH);
  localparam int KEY_BITS = 2 * NODE_ID_BITS + 3;
  localparam int QW = 2 + KEY_BITS + NODE_ID_BITS + 1 + IDX_BITS;
  logic [12:0] tsize_r;
  logic rce_r;
  logic [IDX_BITS:0] size;
  logic q_push, q_full, q_pop, q_empty;
  logic [QW-1:0] q_wdata, q_rdata;

  always_comb begin
    if (tsize_r < 13'd3) size = (IDX_BITS+1)'(3);
    else if (32'(tsize_r) > TABLE_DEPTH) size = (IDX_BITS+1)'(TABLE_DEPTH);
    else size = (IDX_BITS+1)'(tsize_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tsize_r <= sht_pkg::SIZE_RESET;
      rce_r <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == sht_pkg::REG_TABLE_SIZE) tsize_r <= cfg_data;
      else if (cfg_index == sht_pkg::REG_REF_CHECK) rce_r <= cfg_data[0];
    end
  end

  sht_front #(.NODE_ID_BITS(NODE_ID_BITS), .IDX_BITS(IDX_BITS), .KEY_BITS(KEY_BITS),
              .QW(QW)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_operation,
    .in_key({in_is_exor, in_fanin0_id, in_fanin1_id, in_fanin0_inverted,
             in_fanin1_inverted}),
    .in_miss_force(rce_r && (!in_fanin0_referenced || !in_fanin1_referenced)),
    .in_node(in_entry_node_id), .size, .q_push, .q_data(q_wdata), .q_full
  );

  sht_queue #(.QW(QW)) u_queue (
    .clk, .rst_n, .push(q_push), .wdata(q_wdata), .full(q_full), .pop(q_pop),
    .empty(q_empty), .rdata(q_rdata)
  );

  sht_back #(.TABLE_DEPTH(TABLE_DEPTH), .NODE_ID_BITS(NODE_ID_BITS), .IDX_BITS(IDX_BITS),
             .KEY_BITS(KEY_BITS), .QW(QW)) u_back (
    .clk, .rst_n, .size, .q_empty, .q_data(q_rdata), .q_pop, .out_valid, .out_ready,
    .out_status, .out_found_node_id
  );
endmodule

@@ sv/sht_front.sv @@
// Front end: takes transfers, hashes the key, reduces it modulo the table size
module sht_front #(
  parameter int NODE_ID_BITS = sht_pkg::NODE_ID_BITS_DEF,
  parameter int IDX_BITS = 12,
  parameter int KEY_BITS = 2 * NODE_ID_BITS + 3,
  parameter int QW = 2 + KEY_BITS + NODE_ID_BITS + 1 + IDX_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_operation,
  input  logic [KEY_BITS-1:0]     in_key,
  input  logic                    in_miss_force,
  input  logic [NODE_ID_BITS-1:0] in_node,
  input  logic [IDX_BITS:0]       size,
  output logic                    q_push,
  output logic [QW-1:0]           q_data,
  input  logic                    q_full
);
  localparam int HW = NODE_ID_BITS + 13;
  sht_pkg::fe_state_t st_r, st_nxt;
  logic [HW-1:0] rem_r, rem_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic [1:0] op_r;
  logic [KEY_BITS-1:0] key_r;
  logic mf_r;
  logic [NODE_ID_BITS-1:0] node_r;
  logic [HW-1:0] h;
  logic [HW-1:0] sub;
  logic [HW-1:0] szsh;

  always_comb begin
    h = (HW'(in_key[KEY_BITS-1]) * HW'(1699)) ^
        (HW'(in_key[2*NODE_ID_BITS+1:NODE_ID_BITS+2]) * HW'(7937)) ^
        (HW'(in_key[NODE_ID_BITS+1:2]) * HW'(2971)) ^
        (HW'(in_key[1]) * HW'(911)) ^ (HW'(in_key[0]) * HW'(353));
  end

  assign szsh = HW'(size) << cnt_r;
  assign sub = rem_r - szsh;
  assign in_ready = (st_r == sht_pkg::FE_IDLE);
  assign q_data = {op_r, key_r, node_r, mf_r, rem_r[IDX_BITS-1:0]};

  always_comb begin
    st_nxt = st_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    q_push = 1'b0;
    unique case (st_r)
      sht_pkg::FE_IDLE: begin
        if (in_valid) begin
          rem_nxt = h;
          cnt_nxt = 6'(HW - 2);
          st_nxt = sht_pkg::FE_MOD;
        end
      end
      sht_pkg::FE_MOD: begin
        if ((szsh >> cnt_r) == HW'(size) && rem_r >= szsh) rem_nxt = sub;
        if (cnt_r == 6'd0) st_nxt = sht_pkg::FE_PUSH;
        else cnt_nxt = cnt_r - 6'd1;
      end
      sht_pkg::FE_PUSH: begin
        if (!q_full) begin
          q_push = 1'b1;
          st_nxt = sht_pkg::FE_IDLE;
        end
      end
      default: st_nxt = sht_pkg::FE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= sht_pkg::FE_IDLE;
    else st_r <= st_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (in_valid && in_ready) begin
      op_r <= in_operation;
      key_r <= in_key;
      mf_r <= in_miss_force;
      node_r <= in_node;
    end
  end
endmodule

@@ sv/sht_queue.sv @@
// Two-entry queue between the front and back end
module sht_queue #(
  parameter int QW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [QW-1:0] wdata,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output logic [QW-1:0] rdata
);
  logic [QW-1:0] mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  assign full = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rdata = mem_r[rp_r];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
    if (push) mem_r[wp_r] <= wdata;
  end
endmodule

@@ sv/sht_back.sv @@
// Back end: probes the slot memory, carries out lookup, insert and delete, answers a no-op
module sht_back #(
  parameter int TABLE_DEPTH = sht_pkg::TABLE_DEPTH_DEF,
  parameter int NODE_ID_BITS = sht_pkg::NODE_ID_BITS_DEF,
  parameter int IDX_BITS = $clog2(TABLE_DEPTH),
  parameter int KEY_BITS = 2 * NODE_ID_BITS + 3,
  parameter int QW = 2 + KEY_BITS + NODE_ID_BITS + 1 + IDX_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [IDX_BITS:0]       size,
  input  logic                    q_empty,
  input  logic [QW-1:0]           q_data,
  output logic                    q_pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              out_status,
  output logic [NODE_ID_BITS-1:0] out_found_node_id
);
  localparam int EW = KEY_BITS + NODE_ID_BITS;
  localparam int HW = NODE_ID_BITS + 13;
  sht_pkg::be_state_t st_r, st_nxt;
  logic [EW-1:0] ent_mem [TABLE_DEPTH];
  logic val_mem [TABLE_DEPTH];
  logic clr_busy_r;
  logic [IDX_BITS-1:0] clr_idx_r;
  logic [EW-1:0] rd_r;
  logic rv_r;
  logic [IDX_BITS-1:0] idx_r, idx_nxt, hole_r, hole_nxt;
  logic [IDX_BITS:0] n_r, n_nxt, n2_r, n2_nxt, cnt_r, cnt_nxt;
  logic [1:0] op;
  logic [KEY_BITS-1:0] key;
  logic [NODE_ID_BITS-1:0] node;
  logic mf;
  logic [IDX_BITS-1:0] hidx;
  logic [EW-1:0] mv_r, mv_nxt;
  logic [HW-1:0] rem_r, rem_nxt;
  logic [5:0] mc_r, mc_nxt;
  logic [HW-1:0] szsh, rh, rr;
  logic wr_en;
  logic [IDX_BITS-1:0] wr_idx;
  logic [EW-1:0] wr_data;
  logic set_v, clr_v;
  logic [IDX_BITS-1:0] v_idx;
  logic [IDX_BITS-1:0] rd_idx;
  logic ov_r, ov_nxt;
  logic [1:0] os_r, os_nxt;
  logic [NODE_ID_BITS-1:0] of_r, of_nxt;
  logic [IDX_BITS-1:0] inc;

  assign {op, key, node, mf, hidx} = q_data;
  assign inc = (IDX_BITS+1)'(idx_r) + 1'b1 >= size ? '0 : idx_r + 1'b1;
  assign szsh = HW'(size) << mc_r;
  assign rh = (HW'(mv_r[EW-1]) * HW'(1699)) ^
              (HW'(mv_r[EW-2:EW-1-NODE_ID_BITS]) * HW'(7937)) ^
              (HW'(mv_r[EW-1-NODE_ID_BITS-1:NODE_ID_BITS+2]) * HW'(2971)) ^
              (HW'(mv_r[NODE_ID_BITS+1]) * HW'(911)) ^
              (HW'(mv_r[NODE_ID_BITS]) * HW'(353));
  assign out_valid = ov_r;
  assign out_status = os_r;
  assign out_found_node_id = of_r;

  always_comb begin
    st_nxt = st_r;
    idx_nxt = idx_r;
    hole_nxt = hole_r;
    n_nxt = n_r;
    n2_nxt = n2_r;
    cnt_nxt = cnt_r;
    mv_nxt = mv_r;
    rem_nxt = rem_r;
    mc_nxt = mc_r;
    rr = rem_r;
    wr_en = 1'b0;
    wr_idx = idx_r;
    wr_data = {key, node};
    set_v = 1'b0;
    clr_v = 1'b0;
    v_idx = idx_r;
    rd_idx = idx_r;
    q_pop = 1'b0;
    ov_nxt = ov_r && !out_ready;
    os_nxt = os_r;
    of_nxt = of_r;
    unique case (st_r)
      sht_pkg::BE_IDLE: begin
        if (!q_empty && !ov_nxt && !clr_busy_r) begin
          idx_nxt = hidx;
          n_nxt = '0;
          if (op == sht_pkg::OP_LOOKUP && mf) begin
            os_nxt = sht_pkg::ST_MISS; of_nxt = '0; st_nxt = sht_pkg::BE_DONE;
          end else if (op == sht_pkg::OP_INSERT &&
                       {cnt_r, 1'b0} + 2'd2 > {1'b0, size}) begin
            os_nxt = sht_pkg::ST_FULL; of_nxt = '0; st_nxt = sht_pkg::BE_DONE;
          end else if (op == sht_pkg::OP_NONE) begin
            os_nxt = sht_pkg::ST_OK; of_nxt = '0; st_nxt = sht_pkg::BE_DONE;
          end else st_nxt = sht_pkg::BE_RD;
        end
      end
      sht_pkg::BE_RD: st_nxt = sht_pkg::BE_WAIT;
      sht_pkg::BE_WAIT: st_nxt = sht_pkg::BE_CHK;
      sht_pkg::BE_CHK: begin
        of_nxt = '0;
        if (n_r >= size || !rv_r) begin
          if (op == sht_pkg::OP_INSERT && n_r < size) begin
            wr_en = 1'b1; set_v = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
            os_nxt = sht_pkg::ST_OK;
          end else if (op == sht_pkg::OP_INSERT) os_nxt = sht_pkg::ST_FULL;
          else if (op == sht_pkg::OP_LOOKUP) os_nxt = sht_pkg::ST_MISS;
          else os_nxt = sht_pkg::ST_ABSENT;
          st_nxt = sht_pkg::BE_DONE;
        end else if (op == sht_pkg::OP_LOOKUP && rd_r[EW-1:NODE_ID_BITS] == key) begin
          os_nxt = sht_pkg::ST_OK; of_nxt = rd_r[NODE_ID_BITS-1:0];
          st_nxt = sht_pkg::BE_DONE;
        end else if (op == sht_pkg::OP_DELETE && rd_r[NODE_ID_BITS-1:0] == node) begin
          clr_v = 1'b1;
          if (cnt_r != '0) cnt_nxt = cnt_r - 1'b1;
          os_nxt = sht_pkg::ST_OK;
          idx_nxt = inc; n2_nxt = '0;
          st_nxt = sht_pkg::BE_REPL_RD;
        end else begin
          idx_nxt = inc; n_nxt = n_r + 1'b1; st_nxt = sht_pkg::BE_RD;
        end
      end
      sht_pkg::BE_REPL_RD: st_nxt = sht_pkg::BE_REPL_WAIT;
      sht_pkg::BE_REPL_WAIT: st_nxt = sht_pkg::BE_REPL_CHK;
      sht_pkg::BE_REPL_CHK: begin
        if (n2_r >= size || !rv_r) st_nxt = sht_pkg::BE_DONE;
        else begin
          clr_v = 1'b1;
          mv_nxt = rd_r; hole_nxt = idx_r;
          mc_nxt = 6'(HW - 2);
          st_nxt = sht_pkg::BE_REH_MOD;
        end
      end
      sht_pkg::BE_REH_MOD: begin
        rr = (mc_r == 6'(HW - 2)) ? rh : rem_r;
        if ((szsh >> mc_r) == HW'(size) && rr >= szsh) rr = rr - szsh;
        rem_nxt = rr;
        if (mc_r == '0) begin
          idx_nxt = rr[IDX_BITS-1:0]; n_nxt = '0;
          st_nxt = sht_pkg::BE_REH_PROBE_RD;
        end else mc_nxt = mc_r - 1'b1;
      end
      sht_pkg::BE_REH_PROBE_RD: st_nxt = sht_pkg::BE_REH_PROBE_WAIT;
      sht_pkg::BE_REH_PROBE_WAIT: st_nxt = sht_pkg::BE_REH_PROBE_CHK;
      sht_pkg::BE_REH_PROBE_CHK: begin
        if (n_r >= size || !rv_r) begin
          if (n_r < size) begin
            wr_en = 1'b1; wr_data = mv_r; set_v = 1'b1;
          end
          idx_nxt = (IDX_BITS+1)'(hole_r) + 1'b1 >= size ? '0 : hole_r + 1'b1;
          n2_nxt = n2_r + 1'b1;
          st_nxt = sht_pkg::BE_REPL_RD;
        end else begin
          idx_nxt = inc; n_nxt = n_r + 1'b1;
          st_nxt = sht_pkg::BE_REH_PROBE_RD;
        end
      end
      sht_pkg::BE_DONE: begin
        if (!ov_nxt) begin
          ov_nxt = 1'b1; q_pop = 1'b1; st_nxt = sht_pkg::BE_IDLE;
        end
      end
      default: st_nxt = sht_pkg::BE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= sht_pkg::BE_IDLE;
      cnt_r <= '0;
      ov_r <= 1'b0;
      clr_busy_r <= 1'b1;
      clr_idx_r <= '0;
    end else begin
      st_r <= st_nxt;
      cnt_r <= cnt_nxt;
      ov_r <= ov_nxt;
      if (clr_busy_r) begin
        clr_idx_r <= clr_idx_r + 1'b1;
        if (clr_idx_r == IDX_BITS'(TABLE_DEPTH - 1)) clr_busy_r <= 1'b0;
      end
    end
    if (clr_busy_r) val_mem[clr_idx_r] <= 1'b0;
    else if (set_v) val_mem[v_idx] <= 1'b1;
    else if (clr_v) val_mem[v_idx] <= 1'b0;
    if (wr_en) ent_mem[wr_idx] <= wr_data;
    rd_r <= ent_mem[rd_idx];
    rv_r <= val_mem[rd_idx];
    idx_r <= idx_nxt;
    hole_r <= hole_nxt;
    n_r <= n_nxt;
    n2_r <= n2_nxt;
    mv_r <= mv_nxt;
    rem_r <= rem_nxt;
    mc_r <= mc_nxt;
    os_r <= os_nxt;
    of_r <= of_nxt;
  end

  `include "structural_hash_table_core_assert.svh"
  `SHT_ASSERT_IMP(a_pop_done, clk, rst_n, q_pop, st_r == sht_pkg::BE_DONE)
  `SHT_ASSERT_NXT(a_pop_valid, clk, rst_n, q_pop, out_valid)
  `SHT_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_found_node_id))
  `SHT_ASSERT_IMP(a_clear_idle, clk, rst_n, clr_busy_r, st_r == sht_pkg::BE_IDLE)
endmodule

@@ verif/testbench.sv @@
// Testbench for the structural hash table core: directed table plus random traffic
module testbench;
  localparam int DEPTH = sht_pkg::TABLE_DEPTH_DEF;

  typedef struct packed {
    logic        exor;
    logic [15:0] f0;
    logic [15:0] f1;
    logic        c0;
    logic        c1;
    logic [15:0] node;
  } gate_key_t;

  typedef struct packed {
    logic [1:0]  op;
    gate_key_t   key;
    logic        r0;
    logic        r1;
    logic        typed;
    logic [1:0]  st;
    logic [15:0] fnd;
  } dir_row_t;

  typedef struct packed {
    logic [1:0]  st;
    logic [15:0] fnd;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = sht_pkg::REG_TABLE_SIZE;
  logic [12:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_operation = sht_pkg::OP_LOOKUP;
  logic in_is_exor = 1'b0;
  logic [15:0] in_fanin0_id = '0;
  logic [15:0] in_fanin1_id = '0;
  logic in_fanin0_inverted = 1'b0;
  logic in_fanin1_inverted = 1'b0;
  logic in_fanin0_referenced = 1'b0;
  logic in_fanin1_referenced = 1'b0;
  logic [15:0] in_entry_node_id = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_status;
  logic [15:0] out_found_node_id;

  structural_hash_table_core uut (.*);

  always #6 clk = ~clk;

  bit          slot_used [DEPTH];
  gate_key_t   slot_key [DEPTH];
  int unsigned entry_count;
  logic [12:0] size_reg;
  logic        ref_check;

  answer_t     pending_answers[$];
  gate_key_t   recent_keys[$];
  int          errors = 0;
  int          ready_pct = 100;

  function automatic int unsigned live_size();
    int unsigned s;
    s = size_reg;
    if (s < 3) s = 3;
    if (s > DEPTH) s = DEPTH;
    return s;
  endfunction

  function automatic int unsigned key_hash(gate_key_t k, int unsigned s);
    longint unsigned h;
    h = longint'(k.exor) * 64'd1699;
    h ^= longint'(k.f0) * 64'd7937;
    h ^= longint'(k.f1) * 64'd2971;
    h ^= longint'(k.c0) * 64'd911;
    h ^= longint'(k.c1) * 64'd353;
    return int'(h % s);
  endfunction

  function automatic bit key_match(gate_key_t a, gate_key_t b);
    return a.f0 == b.f0 && a.f1 == b.f1 && a.c0 == b.c0 && a.c1 == b.c1 &&
           a.exor == b.exor;
  endfunction

  function automatic bit slot_place(gate_key_t k, int unsigned s);
    int unsigned i;
    i = key_hash(k, s);
    for (int unsigned n = 0; n < s; n++) begin
      if (!slot_used[i]) begin
        slot_used[i] = 1'b1;
        slot_key[i] = k;
        return 1'b1;
      end
      i = (i + 1) % s;
    end
    return 1'b0;
  endfunction

  function automatic answer_t table_step(logic [1:0] op, gate_key_t k, logic r0, logic r1);
    answer_t a;
    int unsigned s;
    int unsigned i;
    int unsigned n;
    bit hit;
    gate_key_t e;
    s = live_size();
    a.st = sht_pkg::ST_OK;
    a.fnd = '0;
    if (op == sht_pkg::OP_LOOKUP) begin
      a.st = sht_pkg::ST_MISS;
      if (!(ref_check && (!r0 || !r1))) begin
        i = key_hash(k, s);
        for (n = 0; n < s && slot_used[i]; n++) begin
          if (key_match(slot_key[i], k)) begin
            a.st = sht_pkg::ST_OK;
            a.fnd = slot_key[i].node;
            break;
          end
          i = (i + 1) % s;
        end
      end
    end else if (op == sht_pkg::OP_INSERT) begin
      if (2 * (entry_count + 1) > s || !slot_place(k, s)) a.st = sht_pkg::ST_FULL;
      else entry_count = (entry_count + 1) & 32'h1FFF;
    end else if (op == sht_pkg::OP_DELETE) begin
      hit = 1'b0;
      i = key_hash(k, s);
      for (n = 0; n < s && slot_used[i]; n++) begin
        if (slot_key[i].node == k.node) begin
          hit = 1'b1;
          break;
        end
        i = (i + 1) % s;
      end
      if (!hit) begin
        a.st = sht_pkg::ST_ABSENT;
      end else begin
        slot_used[i] = 1'b0;
        if (entry_count > 0) entry_count--;
        i = (i + 1) % s;
        for (n = 0; n < s && slot_used[i]; n++) begin
          e = slot_key[i];
          slot_used[i] = 1'b0;
          void'(slot_place(e, s));
          i = (i + 1) % s;
        end
      end
    end
    return a;
  endfunction

  task automatic write_reg(logic [0:0] idx, logic [12:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == sht_pkg::REG_TABLE_SIZE) size_reg = val;
    else ref_check = val[0];
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic send_item(logic [1:0] op, gate_key_t k, logic r0, logic r1,
                           logic typed, answer_t typed_ans);
    answer_t a;
    int gap;
    in_valid <= 1'b1;
    in_operation <= op;
    in_is_exor <= k.exor;
    in_fanin0_id <= k.f0;
    in_fanin1_id <= k.f1;
    in_fanin0_inverted <= k.c0;
    in_fanin1_inverted <= k.c1;
    in_fanin0_referenced <= r0;
    in_fanin1_referenced <= r1;
    in_entry_node_id <= k.node;
    do @(posedge clk); while (!in_ready);
    a = table_step(op, k, r0, r1);
    pending_answers.push_back(typed ? typed_ans : a);
    gap = $urandom_range(0, 99);
    gap = gap < 50 ? 0 : (gap < 90 ? $urandom_range(1, 3) : $urandom_range(10, 40));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic gate_key_t fresh_key(bit narrow);
    gate_key_t k;
    k.exor = 1'($urandom);
    k.c0 = 1'($urandom);
    k.c1 = 1'($urandom);
    k.f0 = narrow ? 16'($urandom_range(0, 15)) : 16'($urandom);
    k.f1 = narrow ? 16'($urandom_range(0, 15)) : 16'($urandom);
    k.node = narrow ? 16'($urandom_range(0, 31)) : 16'($urandom);
    return k;
  endfunction

  task automatic random_item();
    gate_key_t k;
    logic [1:0] op;
    int pick;
    logic r0;
    logic r1;
    if ($urandom_range(0, 99) < 20) begin
      k = fresh_key(0);
      send_item(2'($urandom), k, 1'($urandom), 1'($urandom), 1'b0, '0);
      return;
    end
    pick = $urandom_range(0, 99);
    op = pick < 40 ? sht_pkg::OP_LOOKUP :
         (pick < 75 ? sht_pkg::OP_INSERT : sht_pkg::OP_DELETE);
    if (recent_keys.size() != 0 && $urandom_range(0, 99) < 70)
      k = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
    else
      k = fresh_key(1);
    r0 = $urandom_range(0, 99) < 80;
    r1 = $urandom_range(0, 99) < 80;
    if (op == sht_pkg::OP_INSERT) begin
      if (recent_keys.size() != 0 && $urandom_range(0, 3) != 0)
        k.node = 16'($urandom_range(0, 31));
      recent_keys.push_back(k);
      if (recent_keys.size() > 32) void'(recent_keys.pop_front());
    end
    send_item(op, k, r0, r1, 1'b0, '0);
  endtask

  always @(posedge clk) begin
    out_ready <= $urandom_range(0, 99) < ready_pct;
  end

  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected transfer: status %0d id %0d",
                                   out_status, out_found_node_id);
      end else begin
        want = pending_answers.pop_front();
        if (want.st !== out_status || want.fnd !== out_found_node_id) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected status %0d id %0d, got status %0d id %0d",
                     want.st, want.fnd, out_status, out_found_node_id);
        end
      end
    end
  end

  dir_row_t dir_rows [16] = '{
    '{sht_pkg::OP_LOOKUP, '{1'b0, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0}, 1'b1, 1'b1,
      1'b1, sht_pkg::ST_MISS, 16'h0},
    '{sht_pkg::OP_DELETE, '{1'b0, 16'h0, 16'h0, 1'b0, 1'b0, 16'h7}, 1'b1, 1'b1,
      1'b1, sht_pkg::ST_ABSENT, 16'h0},
    '{sht_pkg::OP_NONE, '{1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF}, 1'b1, 1'b1,
      1'b1, sht_pkg::ST_OK, 16'h0},
    '{sht_pkg::OP_INSERT, '{1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF}, 1'b1, 1'b1,
      1'b1, sht_pkg::ST_OK, 16'h0},
    '{sht_pkg::OP_LOOKUP, '{1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 16'h0}, 1'b0, 1'b0,
      1'b1, sht_pkg::ST_OK, 16'hFFFF},
    '{sht_pkg::OP_INSERT, '{1'b0, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0}, 1'b0, 1'b0,
      1'b1, sht_pkg::ST_OK, 16'h0},
    '{sht_pkg::OP_INSERT, '{1'b0, 16'h0, 16'h0, 1'b0, 1'b0, 16'h5}, 1'b1, 1'b1,
      1'b1, sht_pkg::ST_OK, 16'h0},
    '{sht_pkg::OP_LOOKUP, '{1'b0, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0}, 1'b1, 1'b1,
      1'b1, sht_pkg::ST_OK, 16'h0},
    '{sht_pkg::OP_DELETE, '{1'b0, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0}, 1'b1, 1'b1,
      1'b1, sht_pkg::ST_OK, 16'h0},
    '{sht_pkg::OP_LOOKUP, '{1'b0, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0}, 1'b1, 1'b1,
      1'b0, sht_pkg::ST_OK, 16'h0},
    '{sht_pkg::OP_LOOKUP, '{1'b1, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 16'h0}, 1'b1, 1'b1,
      1'b1, sht_pkg::ST_MISS, 16'h0},
    '{sht_pkg::OP_INSERT, '{1'b0, 16'h1, 16'h2, 1'b1, 1'b0, 16'h3}, 1'b1, 1'b1,
      1'b0, sht_pkg::ST_OK, 16'h0},
    '{sht_pkg::OP_LOOKUP, '{1'b0, 16'h2, 16'h1, 1'b1, 1'b0, 16'h0}, 1'b1, 1'b1,
      1'b0, sht_pkg::ST_OK, 16'h0},
    '{sht_pkg::OP_DELETE, '{1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 16'h1234}, 1'b1, 1'b1,
      1'b0, sht_pkg::ST_OK, 16'h0},
    '{sht_pkg::OP_DELETE, '{1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF}, 1'b1, 1'b1,
      1'b1, sht_pkg::ST_OK, 16'h0},
    '{sht_pkg::OP_LOOKUP, '{1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 16'h0}, 1'b1, 1'b1,
      1'b1, sht_pkg::ST_MISS, 16'h0}
  };

  logic [12:0] phase_sizes [10] = '{13'd3, 13'd13, 13'd0, 13'd61, 13'd8191, 13'd31,
                                    13'd4093, 13'd7, 13'd4096, 13'd1};
  int          phase_ready [3] = '{100, 70, 30};

  initial begin
    answer_t ta;
    for (int i = 0; i < DEPTH; i++) slot_used[i] = 1'b0;
    entry_count = 0;
    size_reg = sht_pkg::SIZE_RESET;
    ref_check = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_rows[r]) begin
      ta.st = dir_rows[r].st;
      ta.fnd = dir_rows[r].fnd;
      send_item(dir_rows[r].op, dir_rows[r].key, dir_rows[r].r0, dir_rows[r].r1,
                dir_rows[r].typed, ta);
    end
    foreach (phase_sizes[p]) begin
      drain();
      write_reg(sht_pkg::REG_TABLE_SIZE, phase_sizes[p]);
      write_reg(sht_pkg::REG_REF_CHECK, 13'(p % 2));
      ready_pct = phase_ready[p % 3];
      repeat (118) random_item();
    end
    drain();
    if (errors == 0) $display("PASS structural_hash_table_core");
    else $display("FAIL structural_hash_table_core");
    $finish;
  end

  initial begin
    #60000000;
    $display("FAIL structural_hash_table_core");
    $finish;
  end
endmodule
